// ----- rtl/core/hcss_pkg.sv -----
// hcss_pkg: field widths and fixed-point constants for the chi-square split search
// no dependencies
`default_nettype none
package hcss_pkg;
  localparam int unsigned SUM_W    = 32;  // q24.8 weight sums
  localparam int unsigned SQ_W     = 40;  // q24.16 squared-weight sums
  localparam int unsigned CHI_W    = 32;  // q16.16 chi-square
  localparam int unsigned MINEV_W  = 24;
  localparam int unsigned MINEV_SH = 8;   // min_events scaled to q24.8
  localparam int unsigned FRAC_SH  = 16;  // diff^2 scaled by 2^16 before dividing
  localparam int unsigned FEAT_W   = 6;
  localparam int unsigned CUT_W    = 7;
  localparam logic [CHI_W-1:0] CHI_MAX = '1;
endpackage
`default_nettype wire

// ----- rtl/core/histogram_chisquare_split_search.sv -----
// histogram_chisquare_split_search: bin store, cut scan and shared multiply/divide unit
// depends on hcss_pkg
`default_nettype none
// usage
//   one item per histogram bin: source and target weight sum and squared-weight sum,
//   underflow bin first, overflow bin (in_last_bin) last. an item is taken on start
//   while busy is low. an ordinary bin leaves busy low.
//   the overflow bin starts a scan over the stored bins of the feature; busy stays
//   high throughout. each candidate cut is squared and divided for its low and its high
//   side in the serial squarer and the restoring divider under the sequencer; a
//   feature of N bins needs about (N-3) such passes.
//   the squarer and divider use their own adder and subtractor, stepped in turn.
//   in_last_bin with in_last_feature ends the search: after the scan the S_FINISH state
//   registers the best cut and out_valid pulses for one cycle (all fields zero if none found).
//   the receiver cannot stall; results are simply dropped if not taken.
//   cfg_wr_en writes min_events; write only while idle.
//   reset (synchronous, rst_n low) clears counters, totals and the best record;
//   the bin memory is not cleared, only entries written for the current feature are read.
module histogram_chisquare_split_search #(
  parameter int unsigned MAX_BINS     = 64,
  parameter int unsigned MAX_FEATURES = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [hcss_pkg::MINEV_W-1:0]  cfg_wr_data,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [hcss_pkg::SUM_W-1:0]    in_src_weight_sum,
  input  wire logic [hcss_pkg::SQ_W-1:0]     in_src_weight_sq_sum,
  input  wire logic [hcss_pkg::SUM_W-1:0]    in_tgt_weight_sum,
  input  wire logic [hcss_pkg::SQ_W-1:0]     in_tgt_weight_sq_sum,
  input  wire logic                          in_last_bin,
  input  wire logic                          in_last_feature,
  output logic                               out_valid,
  output logic                               out_found,
  output logic [hcss_pkg::FEAT_W-1:0]        out_feature_index,
  output logic [hcss_pkg::CUT_W-1:0]         out_cut_bin,
  output logic [hcss_pkg::CHI_W-1:0]         out_chisquare,
  output logic [hcss_pkg::SUM_W-1:0]         out_src_low,
  output logic [hcss_pkg::SUM_W-1:0]         out_tgt_low,
  output logic [hcss_pkg::SUM_W-1:0]         out_src_high,
  output logic [hcss_pkg::SUM_W-1:0]         out_tgt_high
);
  localparam int unsigned DEPTH = MAX_BINS + 2;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned LSW   = hcss_pkg::SUM_W + AW;   // accumulated weight sum
  localparam int unsigned LQW   = hcss_pkg::SQ_W + AW;    // accumulated squared sum
  localparam int unsigned DENW  = LQW + 1;
  localparam int unsigned PW    = 2 * LSW;                // diff squared
  localparam int unsigned HPW   = PW - hcss_pkg::FRAC_SH; // dividend above the low word
  localparam int unsigned CW    = $clog2(LSW + 1);
  localparam int unsigned FCW   = $clog2(MAX_FEATURES + 1);
  localparam int unsigned QW    = hcss_pkg::CHI_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LD0, S_INIT, S_WAIT, S_ACC, S_HIGH, S_QUAL,
    S_MUL, S_SAT, S_DIV, S_TEND, S_UPD, S_FINISH
  } state_t;

  state_t state_r;

  // bin memories
  logic [hcss_pkg::SUM_W-1:0] mem_ss [DEPTH];
  logic [hcss_pkg::SQ_W-1:0]  mem_sq [DEPTH];
  logic [hcss_pkg::SUM_W-1:0] mem_ts [DEPTH];
  logic [hcss_pkg::SQ_W-1:0]  mem_tq [DEPTH];
  logic [hcss_pkg::SUM_W-1:0] rd_ss_r, rd_ts_r;
  logic [hcss_pkg::SQ_W-1:0]  rd_sq_r, rd_tq_r;
  logic [AW-1:0]              addr_r;

  logic [hcss_pkg::MINEV_W-1:0] min_ev_r;
  logic [AW-1:0]  bins_r, bound_r, x_r;
  logic [FCW-1:0] fc_r;
  logic           final_r;
  logic [LSW-1:0] tot_ss_r, tot_ts_r, ls_r, lt_r, hs_r, ht_r;
  logic [LQW-1:0] tot_sq_r, tot_tq_r, ls2_r, lt2_r, hs2_r, ht2_r;

  // shared arithmetic unit state
  logic            term_r;
  logic [LSW-1:0]  diff_r, diff_h_r, mpl_r;
  logic [DENW-1:0] den_r, den_h_r;
  logic [PW-1:0]   prod_r;
  logic [DENW-1:0] rem_r;
  logic [QW-1:0]   lo_r, quot_r;
  logic [CW-1:0]   cnt_r;
  logic [QW:0]     chi_acc_r;

  // best record
  logic                        best_found_r;
  logic [hcss_pkg::FEAT_W-1:0] best_feat_r;
  logic [hcss_pkg::CUT_W-1:0]  best_cut_r;
  logic [QW-1:0]               best_chi_r;
  logic [hcss_pkg::SUM_W-1:0]  best_sl_r, best_tl_r, best_sh_r, best_th_r;

  logic [hcss_pkg::SUM_W-1:0] out_sl_r, out_tl_r, out_sh_r, out_th_r, out_chi_r_w;
  logic                       out_valid_r, out_found_r;
  logic [hcss_pkg::FEAT_W-1:0] out_feat_r;
  logic [hcss_pkg::CUT_W-1:0]  out_cut_r;
  logic [QW-1:0]               out_chi_r;

  logic accept, store_en;
  logic [LSW-1:0] thr;
  logic [DENW:0]  rem_sh;
  logic [DENW:0]  rem_sub;
  logic [PW-1:0]  prod_step;
  logic [QW-1:0]  chi_sat;
  logic [DENW-1:0] den_lo, den_hi;

  function automatic logic [hcss_pkg::SUM_W-1:0] sat32(input logic [LSW-1:0] v);
    if (|v[LSW-1:hcss_pkg::SUM_W]) return '1;
    return v[hcss_pkg::SUM_W-1:0];
  endfunction

  assign busy     = (state_r != S_IDLE);
  assign accept   = start && !busy;
  assign store_en = accept && (in_last_bin || (bins_r < AW'(DEPTH - 1)));
  assign thr      = LSW'({min_ev_r, {hcss_pkg::MINEV_SH{1'b0}}});

  assign rem_sh    = {rem_r, lo_r[QW-1]};
  assign rem_sub   = rem_sh - {1'b0, den_r};
  assign prod_step = {prod_r[PW-2:0], 1'b0} + (mpl_r[LSW-1] ? PW'(diff_r) : PW'(0));
  assign chi_sat   = chi_acc_r[QW] ? hcss_pkg::CHI_MAX : chi_acc_r[QW-1:0];
  assign den_lo    = DENW'(ls2_r) + DENW'(lt2_r);
  assign den_hi    = DENW'(hs2_r) + DENW'(ht2_r);

  // bin memories, registered read
  always_ff @(posedge clk) begin
    if (store_en) begin
      mem_ss[bins_r] <= in_src_weight_sum;
      mem_sq[bins_r] <= in_src_weight_sq_sum;
      mem_ts[bins_r] <= in_tgt_weight_sum;
      mem_tq[bins_r] <= in_tgt_weight_sq_sum;
    end
    rd_ss_r <= mem_ss[addr_r];
    rd_sq_r <= mem_sq[addr_r];
    rd_ts_r <= mem_ts[addr_r];
    rd_tq_r <= mem_tq[addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      min_ev_r     <= '0;
      bins_r       <= '0;
      fc_r         <= '0;
      tot_ss_r     <= '0;
      tot_sq_r     <= '0;
      tot_ts_r     <= '0;
      tot_tq_r     <= '0;
      best_found_r <= 1'b0;
      best_feat_r  <= '0;
      best_cut_r   <= '0;
      best_chi_r   <= '0;
      best_sl_r    <= '0;
      best_tl_r    <= '0;
      best_sh_r    <= '0;
      best_th_r    <= '0;
      out_valid_r  <= 1'b0;
      final_r      <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_wr_en) begin
        min_ev_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (store_en) begin
            tot_ss_r <= tot_ss_r + LSW'(in_src_weight_sum);
            tot_sq_r <= tot_sq_r + LQW'(in_src_weight_sq_sum);
            tot_ts_r <= tot_ts_r + LSW'(in_tgt_weight_sum);
            tot_tq_r <= tot_tq_r + LQW'(in_tgt_weight_sq_sum);
            if (!in_last_bin) begin
              bins_r <= bins_r + AW'(1);
            end else begin
              final_r <= in_last_feature;
              bound_r <= bins_r - AW'(1);  // regular bin count
              addr_r  <= '0;
              if ((fc_r < FCW'(MAX_FEATURES)) && (bins_r >= AW'(3))) begin
                state_r <= S_LD0;
              end else begin
                state_r <= S_FINISH;
              end
            end
          end
        end
        S_LD0: state_r <= S_INIT;
        S_INIT: begin
          // underflow bin seeds the low side
          ls_r    <= LSW'(rd_ss_r);
          ls2_r   <= LQW'(rd_sq_r);
          lt_r    <= LSW'(rd_ts_r);
          lt2_r   <= LQW'(rd_tq_r);
          x_r     <= AW'(1);
          addr_r  <= AW'(1);
          state_r <= S_WAIT;
        end
        S_WAIT: state_r <= S_ACC;
        S_ACC: begin
          ls_r    <= ls_r + LSW'(rd_ss_r);
          ls2_r   <= ls2_r + LQW'(rd_sq_r);
          lt_r    <= lt_r + LSW'(rd_ts_r);
          lt2_r   <= lt2_r + LQW'(rd_tq_r);
          state_r <= S_HIGH;
        end
        S_HIGH: begin
          hs_r    <= tot_ss_r - ls_r;
          hs2_r   <= tot_sq_r - ls2_r;
          ht_r    <= tot_ts_r - lt_r;
          ht2_r   <= tot_tq_r - lt2_r;
          state_r <= S_QUAL;
        end
        S_QUAL: begin
          diff_r    <= (ls_r > lt_r) ? ls_r - lt_r : lt_r - ls_r;
          diff_h_r  <= (hs_r > ht_r) ? hs_r - ht_r : ht_r - hs_r;
          mpl_r     <= (ls_r > lt_r) ? ls_r - lt_r : lt_r - ls_r;
          den_r     <= den_lo;
          den_h_r   <= den_hi;
          prod_r    <= '0;
          cnt_r     <= CW'(LSW - 1);
          term_r    <= 1'b0;
          chi_acc_r <= '0;
          if ((ls_r < thr) || (hs_r < thr) || (lt_r < thr) || (ht_r < thr) ||
              (den_lo == '0) || (den_hi == '0)) begin
            state_r <= S_UPD;
          end else begin
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          // serial square, multiplier msb first
          prod_r <= prod_step;
          mpl_r  <= {mpl_r[LSW-2:0], 1'b0};
          cnt_r  <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            state_r <= S_SAT;
          end
        end
        S_SAT: begin
          // quotient needs more than 32 bits when the upper dividend reaches den
          if (prod_r[PW-1:hcss_pkg::FRAC_SH] >= HPW'(den_r)) begin
            quot_r  <= hcss_pkg::CHI_MAX;
            state_r <= S_TEND;
          end else begin
            rem_r   <= prod_r[hcss_pkg::FRAC_SH +: DENW];
            lo_r    <= {prod_r[hcss_pkg::FRAC_SH-1:0], {(QW-hcss_pkg::FRAC_SH){1'b0}}};
            quot_r  <= '0;
            cnt_r   <= CW'(QW - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // restoring division, one quotient bit a cycle
          if (!rem_sub[DENW]) begin
            rem_r  <= rem_sub[DENW-1:0];
            quot_r <= {quot_r[QW-2:0], 1'b1};
          end else begin
            rem_r  <= rem_sh[DENW-1:0];
            quot_r <= {quot_r[QW-2:0], 1'b0};
          end
          lo_r  <= {lo_r[QW-2:0], 1'b0};
          cnt_r <= cnt_r - CW'(1);
          if (cnt_r == '0) begin
            state_r <= S_TEND;
          end
        end
        S_TEND: begin
          chi_acc_r <= chi_acc_r + (QW+1)'(quot_r);
          if (!term_r) begin
            term_r  <= 1'b1;
            diff_r  <= diff_h_r;
            mpl_r   <= diff_h_r;
            den_r   <= den_h_r;
            prod_r  <= '0;
            cnt_r   <= CW'(LSW - 1);
            state_r <= S_MUL;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if ((chi_sat != '0) && (!best_found_r || (chi_sat > best_chi_r))) begin
            best_found_r <= 1'b1;
            best_feat_r  <= hcss_pkg::FEAT_W'(fc_r);
            best_cut_r   <= hcss_pkg::CUT_W'(x_r + AW'(1));
            best_chi_r   <= chi_sat;
            best_sl_r    <= sat32(ls_r);
            best_tl_r    <= sat32(lt_r);
            best_sh_r    <= sat32(hs_r);
            best_th_r    <= sat32(ht_r);
          end
          if ((x_r + AW'(1)) < bound_r) begin
            x_r     <= x_r + AW'(1);
            addr_r  <= x_r + AW'(1);
            state_r <= S_WAIT;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          bins_r   <= '0;
          tot_ss_r <= '0;
          tot_sq_r <= '0;
          tot_ts_r <= '0;
          tot_tq_r <= '0;
          state_r  <= S_IDLE;
          if (fc_r < FCW'(MAX_FEATURES)) begin
            fc_r <= fc_r + FCW'(1);
          end
          if (final_r) begin
            out_valid_r  <= 1'b1;
            out_found_r  <= best_found_r;
            out_feat_r   <= best_feat_r;
            out_cut_r    <= best_cut_r;
            out_chi_r    <= best_chi_r;
            out_sl_r     <= best_sl_r;
            out_tl_r     <= best_tl_r;
            out_sh_r     <= best_sh_r;
            out_th_r     <= best_th_r;
            fc_r         <= '0;
            best_found_r <= 1'b0;
            best_feat_r  <= '0;
            best_cut_r   <= '0;
            best_chi_r   <= '0;
            best_sl_r    <= '0;
            best_tl_r    <= '0;
            best_sh_r    <= '0;
            best_th_r    <= '0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_chi_r_w       = out_chi_r;
  assign out_valid         = out_valid_r;
  assign out_found         = out_found_r;
  assign out_feature_index = out_feat_r;
  assign out_cut_bin       = out_cut_r;
  assign out_chisquare     = out_chi_r_w;
  assign out_src_low       = out_sl_r;
  assign out_tgt_low       = out_tl_r;
  assign out_src_high      = out_sh_r;
  assign out_tgt_high      = out_th_r;

  // checks
  a_single_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe longer than one cycle");
  a_div_den: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (den_r != '0)) else $error("divide by zero");
  a_cut_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) |-> ((x_r < bound_r) && (x_r != '0))) else $error("cut out of range");
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_chi_r == '0)) else $error("stale chi on empty result");
endmodule
`default_nettype wire

// ----- bench/histogram_chisquare_split_search_tb.sv -----
// histogram_chisquare_split_search_tb: self-checking bench for the chi-square split search
// depends on hcss_pkg and histogram_chisquare_split_search; bins are fed from a queue,
// a local predictor scores every cut and the monitor compares each reported best cut
`timescale 1ns / 1ps
module histogram_chisquare_split_search_tb;

  localparam int unsigned NBINS     = 64;
  localparam int unsigned NFEATS    = 64;
  localparam int unsigned DEPTH     = NBINS + 2;
  localparam int unsigned WD_LIMIT  = 100000;
  localparam int unsigned N_ITEMS   = 900;

  // one histogram bin as it goes over the input handshake
  typedef struct {
    logic [hcss_pkg::SUM_W-1:0] src_sum;
    logic [hcss_pkg::SQ_W-1:0]  src_sq;
    logic [hcss_pkg::SUM_W-1:0] tgt_sum;
    logic [hcss_pkg::SQ_W-1:0]  tgt_sq;
    logic                       last_bin;
    logic                       last_feature;
  } bin_item_t;

  // best cut of a finished search
  typedef struct {
    logic                        found;
    logic [hcss_pkg::FEAT_W-1:0] feature;
    logic [hcss_pkg::CUT_W-1:0]  cut;
    logic [hcss_pkg::CHI_W-1:0]  chi;
    logic [hcss_pkg::SUM_W-1:0]  src_low;
    logic [hcss_pkg::SUM_W-1:0]  tgt_low;
    logic [hcss_pkg::SUM_W-1:0]  src_high;
    logic [hcss_pkg::SUM_W-1:0]  tgt_high;
  } best_cut_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  logic [hcss_pkg::MINEV_W-1:0] cfg_wr_data = '0;
  logic start = 1'b0;
  logic busy;
  logic [hcss_pkg::SUM_W-1:0] in_src_weight_sum = '0;
  logic [hcss_pkg::SQ_W-1:0]  in_src_weight_sq_sum = '0;
  logic [hcss_pkg::SUM_W-1:0] in_tgt_weight_sum = '0;
  logic [hcss_pkg::SQ_W-1:0]  in_tgt_weight_sq_sum = '0;
  logic in_last_bin = 1'b0;
  logic in_last_feature = 1'b0;
  logic out_valid, out_found;
  logic [hcss_pkg::FEAT_W-1:0] out_feature_index;
  logic [hcss_pkg::CUT_W-1:0]  out_cut_bin;
  logic [hcss_pkg::CHI_W-1:0]  out_chisquare;
  logic [hcss_pkg::SUM_W-1:0]  out_src_low, out_tgt_low, out_src_high, out_tgt_high;

  always #10 clk = ~clk;

  histogram_chisquare_split_search #(
    .MAX_BINS(NBINS),
    .MAX_FEATURES(NFEATS)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .start(start),
    .busy(busy),
    .in_src_weight_sum(in_src_weight_sum),
    .in_src_weight_sq_sum(in_src_weight_sq_sum),
    .in_tgt_weight_sum(in_tgt_weight_sum),
    .in_tgt_weight_sq_sum(in_tgt_weight_sq_sum),
    .in_last_bin(in_last_bin),
    .in_last_feature(in_last_feature),
    .out_valid(out_valid),
    .out_found(out_found),
    .out_feature_index(out_feature_index),
    .out_cut_bin(out_cut_bin),
    .out_chisquare(out_chisquare),
    .out_src_low(out_src_low),
    .out_tgt_low(out_tgt_low),
    .out_src_high(out_src_high),
    .out_tgt_high(out_tgt_high)
  );

  bin_item_t pending_bins[$];
  best_cut_t expected_cuts[$];
  int unsigned items_queued = 0;
  int unsigned mismatches = 0;

  task automatic add_bin(bin_item_t b);
    pending_bins.insert(pending_bins.size(), b);
  endtask

  task automatic add_expected(best_cut_t c);
    expected_cuts.insert(expected_cuts.size(), c);
  endtask

  // predictor state, mirrors the block
  logic [hcss_pkg::MINEV_W-1:0] min_events_q = '0;
  logic [63:0] src_sum_mem[DEPTH];
  logic [63:0] src_sq_mem[DEPTH];
  logic [63:0] tgt_sum_mem[DEPTH];
  logic [63:0] tgt_sq_mem[DEPTH];
  int unsigned stored_bins = 0;
  int unsigned feature_no = 0;
  logic [63:0] tot_src, tot_src_sq, tot_tgt, tot_tgt_sq;
  best_cut_t best_so_far;

  function automatic logic [63:0] clip32(logic [63:0] v);
    return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
  endfunction

  // diff^2 * 2^16 / den, truncated and clipped to 32 bits
  function automatic logic [63:0] chi_part(logic [63:0] diff, logic [63:0] den);
    logic [127:0] num;
    logic [127:0] quo;
    num = 128'(diff);
    num = (num * num) << hcss_pkg::FRAC_SH;
    quo = num / 128'(den);
    return (quo > 128'hFFFF_FFFF) ? 64'hFFFF_FFFF : quo[63:0];
  endfunction

  // score every cut of the feature just closed
  task automatic score_feature(int unsigned nbins, int unsigned feat);
    logic [63:0] thr, ls, lt, ls2, lt2, hs, ht, hs2, ht2, dl, dh, chi;
    thr = 64'(min_events_q) << hcss_pkg::MINEV_SH;
    ls = src_sum_mem[0];
    lt = tgt_sum_mem[0];
    ls2 = src_sq_mem[0];
    lt2 = tgt_sq_mem[0];
    if (nbins < 4) return;
    for (int unsigned x = 1; x < nbins - 2; x++) begin
      ls += src_sum_mem[x];
      lt += tgt_sum_mem[x];
      ls2 += src_sq_mem[x];
      lt2 += tgt_sq_mem[x];
      hs = tot_src - ls;
      hs2 = tot_src_sq - ls2;
      ht = tot_tgt - lt;
      ht2 = tot_tgt_sq - lt2;
      if (ls < thr || hs < thr || lt < thr || ht < thr) continue;
      if (ls2 + lt2 == 0 || hs2 + ht2 == 0) continue;
      dl = (ls > lt) ? ls - lt : lt - ls;
      dh = (hs > ht) ? hs - ht : ht - hs;
      chi = clip32(chi_part(dl, ls2 + lt2) + chi_part(dh, hs2 + ht2));
      // strict maximum, so the earliest cut keeps a tie
      if (chi != 0 && (!best_so_far.found || chi[31:0] > best_so_far.chi)) begin
        best_so_far.found = 1'b1;
        best_so_far.feature = feat[hcss_pkg::FEAT_W-1:0];
        best_so_far.cut = 7'(x + 1);
        best_so_far.chi = chi[31:0];
        best_so_far.src_low = 32'(clip32(ls));
        best_so_far.tgt_low = 32'(clip32(lt));
        best_so_far.src_high = 32'(clip32(hs));
        best_so_far.tgt_high = 32'(clip32(ht));
      end
    end
  endtask

  // one accepted bin into the predictor
  task automatic take_bin(bin_item_t b);
    int unsigned slot;
    if (!b.last_bin && stored_bins >= DEPTH - 1) return;  // surplus regular bins dropped
    slot = stored_bins;
    src_sum_mem[slot] = 64'(b.src_sum);
    src_sq_mem[slot] = 64'(b.src_sq);
    tgt_sum_mem[slot] = 64'(b.tgt_sum);
    tgt_sq_mem[slot] = 64'(b.tgt_sq);
    tot_src += 64'(b.src_sum);
    tot_src_sq += 64'(b.src_sq);
    tot_tgt += 64'(b.tgt_sum);
    tot_tgt_sq += 64'(b.tgt_sq);
    if (!b.last_bin) begin
      stored_bins++;
      return;
    end
    // features past the limit are loaded but not scored
    if (feature_no < NFEATS) begin
      score_feature(slot + 1, feature_no);
      feature_no++;
    end
    stored_bins = 0;
    tot_src = '0;
    tot_src_sq = '0;
    tot_tgt = '0;
    tot_tgt_sq = '0;
    if (!b.last_feature) return;
    add_expected(best_so_far);
    feature_no = 0;
    best_so_far = '{default: '0};
  endtask

  // stimulus helpers: value style 0 small, 1 full range, 2 extremes, 3 all zero
  function automatic bin_item_t make_bin(int style, logic lb, logic lf);
    bin_item_t b;
    case (style)
      0: begin
        b.src_sum = $urandom_range(0, 4095);
        b.tgt_sum = $urandom_range(0, 4095);
        b.src_sq = 40'($urandom_range(0, 65535));
        b.tgt_sq = 40'($urandom_range(0, 65535));
      end
      1: begin
        b.src_sum = $urandom;
        b.tgt_sum = $urandom;
        b.src_sq = 40'({$urandom, $urandom});
        b.tgt_sq = 40'({$urandom, $urandom});
      end
      2: begin
        b.src_sum = $urandom_range(0, 1) ? '1 : '0;
        b.tgt_sum = $urandom_range(0, 1) ? '1 : '0;
        b.src_sq = $urandom_range(0, 1) ? '1 : '0;
        b.tgt_sq = $urandom_range(0, 1) ? '1 : '0;
      end
      default: begin
        b.src_sum = '0;
        b.tgt_sum = '0;
        b.src_sq = '0;
        b.tgt_sq = '0;
      end
    endcase
    b.last_bin = lb;
    b.last_feature = lf;
    return b;
  endfunction

  // one feature: underflow, regular bins, overflow; stray final flags on ordinary bins
  task automatic queue_feature(int unsigned n_regular, int style, logic closes);
    for (int unsigned i = 0; i <= n_regular; i++) begin
      add_bin(make_bin(style, 1'b0, $urandom_range(0, 7) == 0));
      items_queued++;
    end
    add_bin(make_bin(style, 1'b1, closes));
    items_queued++;
  endtask

  task automatic queue_search(int unsigned n_feat, int style);
    int unsigned nreg;
    for (int unsigned f = 0; f < n_feat; f++) begin
      case ($urandom_range(0, 19))
        0:       nreg = $urandom_range(60, 70);  // full and overfull features, rare
        1, 2:    nreg = $urandom_range(0, 1);    // too short to score
        default: nreg = $urandom_range(2, 8);
      endcase
      queue_feature(nreg, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : style,
                    f == n_feat - 1);
    end
  endtask

  // driver: bursts of items with random gaps
  bin_item_t cur_bin;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) take_bin(cur_bin);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_bins.size() > 0) begin
          cur_bin = pending_bins.pop_front();
          in_src_weight_sum <= cur_bin.src_sum;
          in_src_weight_sq_sum <= cur_bin.src_sq;
          in_tgt_weight_sum <= cur_bin.tgt_sum;
          in_tgt_weight_sq_sum <= cur_bin.tgt_sq;
          in_last_bin <= cur_bin.last_bin;
          in_last_feature <= cur_bin.last_feature;
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            // a quarter of the bursts run straight on
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // monitor and watchdog
  best_cut_t want;
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_cuts.size() == 0) begin
        $error("unexpected result: found %0b chisquare %0h", out_found, out_chisquare);
        mismatches++;
      end else begin
        want = expected_cuts.pop_front();
        check_field("found", 64'(want.found), 64'(out_found));
        check_field("feature_index", 64'(want.feature), 64'(out_feature_index));
        check_field("cut_bin", 64'(want.cut), 64'(out_cut_bin));
        check_field("chisquare", 64'(want.chi), 64'(out_chisquare));
        check_field("src_low", 64'(want.src_low), 64'(out_src_low));
        check_field("tgt_low", 64'(want.tgt_low), 64'(out_tgt_low));
        check_field("src_high", 64'(want.src_high), 64'(out_src_high));
        check_field("tgt_high", 64'(want.tgt_high), 64'(out_tgt_high));
      end
    end
    if ((start && !busy) || out_valid || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WD_LIMIT) begin
      $display("histogram_chisquare_split_search_tb NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // wait for every queued item and every result, then let any scan settle
  task automatic wait_drained();
    do @(posedge clk); while (pending_bins.size() != 0 || start || busy ||
                              expected_cuts.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_min_events(logic [hcss_pkg::MINEV_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    min_events_q = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  logic [hcss_pkg::MINEV_W-1:0] setting;

  initial begin
    best_so_far = '{default: '0};
    tot_src = '0;
    tot_src_sq = '0;
    tot_tgt = '0;
    tot_tgt_sq = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty histogram, short feature, a tie, an overfull feature, full-scale values
    write_min_events('0);
    queue_feature(2, 3, 1'b1);               // nothing above zero
    queue_feature(1, 0, 1'b0);               // short feature
    queue_feature(3, 2, 1'b0);
    add_bin(make_bin(1, 1'b0, 1'b1));        // stray final flag
    add_bin(make_bin(1, 1'b0, 1'b0));
    add_bin(make_bin(1, 1'b0, 1'b0));
    add_bin(make_bin(1, 1'b1, 1'b1));
    items_queued += 4;
    wait_drained();
    // two identical features: the first one must keep the tie
    for (int k = 0; k < 2; k++) begin
      add_bin('{'0, 40'h100, 32'h100, '0, 1'b0, 1'b0});
      add_bin('{32'h300, 40'h100, 32'h100, 40'h100, 1'b0, 1'b0});
      add_bin('{32'h100, 40'h100, 32'h400, 40'h100, 1'b0, 1'b0});
      add_bin('{'1, '1, '0, '1, 1'b1, k == 1});
      items_queued += 4;
    end
    queue_feature(70, 0, 1'b1);              // overfull feature
    wait_drained();
    write_min_events('1);                   // highest threshold needs full-scale sums
    queue_search(2, 2);
    wait_drained();

    // one search with more features than the block scores
    write_min_events(24'd1);
    for (int f = 0; f < NFEATS + 3; f++) queue_feature(2, 0, f == NFEATS + 2);
    wait_drained();

    // random phases, each with its own threshold
    while (items_queued < N_ITEMS) begin
      case ($urandom_range(0, 5))
        0:       setting = '0;
        1:       setting = '1;
        2:       setting = 24'($urandom);
        default: setting = 24'($urandom_range(0, 24));
      endcase
      write_min_events(setting);
      for (int s = $urandom_range(2, 6); s > 0; s--)
        queue_search($urandom_range(1, 4), (setting > 100) ? 2 : $urandom_range(0, 1));
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("histogram_chisquare_split_search_tb OK");
    end else begin
      $display("histogram_chisquare_split_search_tb NOT OK");
    end
    $finish;
  end
endmodule
